// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared geometry constants, command codes, beat types and the FSM encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_POS   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CELL = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_word;
    } t_result;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_SCROLL
    } t_state;

    // Linear cell index of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W+ROW_W:0] prod;
        begin
            prod = (ADDR_W+ROW_W+1)'(row) * (ADDR_W+ROW_W+1)'(COLUMNS)
                 + (ADDR_W+ROW_W+1)'(col);
            return prod[ADDR_W-1:0];
        end
    endfunction

    // Cursor position as reported in a result beat.
    function automatic logic [POS_W-1:0] cursor_pos(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W+POS_W-1:0] wide;
        begin
            wide = (ADDR_W+POS_W)'(cell_addr(row, col));
            return wide[POS_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/tcw_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine with an 80x25 cell RAM, cursor and scroll logic.
// ----------------------------------------------------------------------------
// Usage: a command beat (i_cmd) is taken at a rising edge where start is high
// and busy is low. Every command produces exactly one result beat on o_result,
// marked by o_done for a single cycle; the receiver cannot stall it.
// The result carries the linear cursor position after the command and, for
// read cell, the addressed cell word (zero otherwise).
// Put char, backspace, set position and an out-of-range read report in the
// cycle after acceptance, and busy stays low, so these run one per cycle.
// A read cell reports after the registered RAM read, by way of S_READ.
// Clear walks the RAM one cell a cycle, blanking every cell, then reports.
// A put char or newline that leaves the last row scrolls: the upper 24 rows
// are copied up by one row, then the bottom row is filled with blanks, and
// the result appears once that fill is done.
// Rate is set by the single write port of the cell RAM.
// Reset: the cursor homes and a clearing pass writes 0x0F20 to all 2000 cells,
// with busy high throughout and no result beat.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tcw_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output tcw_pkg::t_result o_result
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_CELL = AW'(tcw_pkg::CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

    // Control state.
    tcw_pkg::t_state r_state, n_state;
    logic [tcw_pkg::COL_W-1:0] r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [AW-1:0] r_cnt, n_cnt;          // Sweep pointer for fill and scroll.
    logic [AW-1:0] r_wptr, n_wptr;        // Destination of the pending copy.
    logic r_pend, n_pend;                 // A scroll read is in flight.
    logic r_reply, n_reply;               // The current fill ends with a result beat.
    logic r_done, n_done;
    tcw_pkg::t_result r_res, n_res;

    // RAM port signals.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    // Range checks against the geometry, one bit wider than the fields.
    logic col_oob;
    logic row_oob;

    assign col_oob = ({1'b0, i_cmd.column} >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
    assign row_oob = ({1'b0, i_cmd.row} >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));

    tcw_cell_ram #(
        .DEPTH  (tcw_pkg::CELLS),
        .WIDTH  (tcw_pkg::CELL_W),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_FILL;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_wptr  <= '0;
            r_pend  <= 1'b0;
            r_reply <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            r_wptr  <= n_wptr;
            r_pend  <= n_pend;
            r_reply <= n_reply;
            r_done  <= n_done;
        end
    end

    // The result beat needs no reset; it is only looked at under o_done.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_cnt     = r_cnt;
        n_wptr    = r_wptr;
        n_pend    = r_pend;
        n_reply   = r_reply;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = tcw_pkg::cell_addr(r_row, r_col);
        ram_wdata = tcw_pkg::BLANK_CELL;
        ram_raddr = tcw_pkg::cell_addr(i_cmd.row, i_cmd.column);

        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (start) begin
                    // Most commands answer in the next cycle with no cell word.
                    n_done = 1'b1;
                    unique case (i_cmd.operation)
                        tcw_pkg::OP_PUT_CHAR: begin
                            if (i_cmd.char_code != tcw_pkg::NEWLINE_CODE) begin
                                ram_we    = 1'b1;
                                ram_wdata = {i_cmd.attribute, i_cmd.char_code};
                            end
                            if (i_cmd.char_code == tcw_pkg::NEWLINE_CODE ||
                                r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    // Leaving the last row: scroll before answering.
                                    n_done  = 1'b0;
                                    n_state = tcw_pkg::S_SCROLL;
                                    n_cnt   = '0;
                                    n_pend  = 1'b0;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcw_pkg::OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col     = r_col - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = tcw_pkg::cell_addr(r_row, r_col - 1'b1);
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_done  = 1'b0;
                            n_col   = '0;
                            n_row   = '0;
                            n_state = tcw_pkg::S_FILL;
                            n_cnt   = '0;
                            n_reply = 1'b1;
                        end
                        tcw_pkg::OP_SET_POS: begin
                            n_col = col_oob ? LAST_COL : i_cmd.column;
                            n_row = row_oob ? LAST_ROW : i_cmd.row;
                        end
                        tcw_pkg::OP_READ_CELL: begin
                            // In range: go to S_READ to wait for the registered read data.
                            if (!col_oob && !row_oob) begin
                                n_done  = 1'b0;
                                n_state = tcw_pkg::S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.cursor_position = tcw_pkg::cursor_pos(n_row, n_col);
                    n_res.cell_word       = '0;
                end
            end

            tcw_pkg::S_READ: begin
                n_done                = 1'b1;
                n_res.cursor_position = tcw_pkg::cursor_pos(r_row, r_col);
                n_res.cell_word       = ram_rdata;
                n_state               = tcw_pkg::S_IDLE;
            end

            tcw_pkg::S_SCROLL: begin
                // Pipelined copy: read cell cnt+COLUMNS now, write it to cnt
                // in the next cycle when the read data arrives.
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr;
                    ram_wdata = ram_rdata;
                end
                ram_raddr = AW'(r_cnt + AW'(tcw_pkg::COLUMNS));
                if (r_cnt != COPY_END) begin
                    n_pend = 1'b1;
                    n_wptr = r_cnt;
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    // Copy done; blank the bottom row starting at COPY_END.
                    n_pend  = 1'b0;
                    n_state = tcw_pkg::S_FILL;
                    n_reply = 1'b1;
                end
            end

            tcw_pkg::S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = tcw_pkg::BLANK_CELL;
                if (r_cnt == LAST_CELL) begin
                    n_state = tcw_pkg::S_IDLE;
                    n_reply = 1'b0;
                    if (r_reply) begin
                        n_done                = 1'b1;
                        n_res.cursor_position = tcw_pkg::cursor_pos(r_row, r_col);
                        n_res.cell_word       = '0;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != tcw_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
